// File: hdl/gle_pkg.sv
// Shared types, constants and character decode for the glyph layout engine.
package gle_pkg;

    // Widths of the shared divider: dividend and divisor share one width.
    localparam int DIV_W = 11;
    localparam int DIV_CNT_W = 4;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_LOWER_N   = 8'd110;

    localparam logic [6:0] GLYPH_BACKSLASH = 7'd59;
    localparam logic [6:0] GLYPH_SPACE     = 7'd95;

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_GLYPH_WIDTH   = 3'd2,
        REG_GLYPH_HEIGHT  = 3'd3,
        REG_GLYPH_PADDING = 3'd4,
        REG_ATLAS_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        KIND_GLYPH = 1'b0,
        KIND_ERROR = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic       printable;
        logic [6:0] index;
    } glyph_code_t;

    // Map a printable byte to its glyph number.
    function automatic glyph_code_t gle_decode(input logic [7:0] c);
        glyph_code_t g;
        g.printable = 1'b0;
        g.index     = '0;
        if (c >= 8'd33 && c <= 8'd123)
        begin
            g.printable = 1'b1;
            g.index     = 7'(c - 8'd33);
        end
        else if (c >= 8'd124 && c <= 8'd126)
        begin
            g.printable = 1'b1;
            g.index     = 7'(c - 8'd32);
        end
        else if (c == CH_SPACE)
        begin
            g.printable = 1'b1;
            g.index     = GLYPH_SPACE;
        end
        return g;
    endfunction

endpackage

// File: hdl/glyph_layout_engine.sv
// Top level: text byte sequencer, pen state and result register of the layout engine.
//
//  channel  direction  tdata                 tuser          tlast
//  s_*      in         char_code             start_of_text  end_of_text
//  m_*      out        glyph/screen/atlas    kind           last_of_run
//  cfg_*    in         register write (index, data), no read-back
//
// A printable byte (glyph_width not 0) passes decode, the shared divider for n div columns
// (11 steps and the done cycle), two multiply steps and the result load. A write to
// glyph_width or atlas_width makes the next glyph redo the column count in the divider. A
// held backslash before any byte but 'n' adds one glyph pass. Newline, escaped break and a
// held backslash end at decode, unknown bytes at the load. s_tready is high only in idle; a
// stalled m_tready holds the sequencer at its result load. Reset restores defaults.
module glyph_layout_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] start_of_text
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [6:0] glyph_index, [22:7] screen_x, [38:23] screen_y,
                                   // [54:39] atlas_u, [70:55] atlas_v, [71] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);
    import gle_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_COLS   = 7'b0000100,
        S_DIVN   = 7'b0001000,
        S_MULU   = 7'b0010000,
        S_MULV   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0] origin_x_reg, origin_y_reg;
    logic [7:0] glyph_width_reg, glyph_height_reg, glyph_padding_reg;
    logic [9:0] atlas_width_reg;

    // layout state
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] pen_y_reg, pen_y_next;
    logic        first_reg, first_next;
    logic        pending_reg, pending_next;

    // item in work
    logic [7:0]       char_reg;
    logic             eot_reg;
    logic             second_reg, second_next;
    result_kind_t     kind_reg, kind_next;
    logic [6:0]       idx_reg, idx_next;
    logic [DIV_W-1:0] cols_reg, cols_next;
    logic             cols_valid_reg, cols_valid_next;
    logic [6:0]       quo_reg, quo_next;
    logic [6:0]       rem_reg, rem_next;
    logic [15:0]      u_reg, u_next;
    logic [15:0]      v_reg, v_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg, out_data_next;
    logic        out_kind_reg, out_kind_next;
    logic        out_last_reg, out_last_next;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    glyph_code_t code;
    logic [6:0]  glyph_n;
    logic        go_glyph;
    logic        do_break;
    logic        makes_result;
    logic [6:0]  mul_a;
    logic [7:0]  mul_b;
    logic [14:0] mul_p;
    logic [15:0] step_x, step_y;
    logic [15:0] screen_x, screen_y;
    logic [DIV_W-1:0] cols_calc;
    logic        s_accept;
    logic        out_free;

    gle_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign code     = gle_decode(char_reg);
    assign step_x   = 16'(glyph_width_reg) + 16'(glyph_padding_reg);
    assign step_y   = 16'(glyph_height_reg) + 16'(glyph_padding_reg);
    assign screen_x = 16'(origin_x_reg) + pen_x_reg;
    assign screen_y = 16'(origin_y_reg) + pen_y_reg;
    assign cols_calc = (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
    assign makes_result = (char_reg != CH_NEWLINE)
                        && !(char_reg == CH_BACKSLASH && !eot_reg);

    // shared multiplier: remainder by width, then quotient by height
    assign mul_a = (state_reg == S_MULV) ? quo_reg : rem_reg;
    assign mul_b = (state_reg == S_MULV) ? glyph_height_reg : glyph_width_reg;
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        first_next      = first_reg;
        pending_next    = pending_reg;
        second_next     = second_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        cols_next       = cols_reg;
        cols_valid_next = cols_valid_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        glyph_n  = code.index;
        go_glyph = 1'b0;
        do_break = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(glyph_n);
        div_req.divisor  = cols_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser)
                    begin
                        pen_x_next   = '0;
                        pen_y_next   = '0;
                        first_next   = 1'b1;
                        pending_next = 1'b0;
                    end
                    second_next = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    if (char_reg == CH_LOWER_N)
                    begin
                        do_break = 1'b1;
                    end
                    else
                    begin
                        // emit the held backslash, then come back for this byte
                        glyph_n     = GLYPH_BACKSLASH;
                        second_next = 1'b1;
                        go_glyph    = 1'b1;
                    end
                end
                else if (char_reg == CH_NEWLINE)
                begin
                    do_break = 1'b1;
                end
                else if (char_reg == CH_BACKSLASH)
                begin
                    if (eot_reg)
                    begin
                        glyph_n  = GLYPH_BACKSLASH;
                        go_glyph = 1'b1;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                    end
                end
                else if (code.printable)
                begin
                    go_glyph = 1'b1;
                end
                else
                begin
                    kind_next  = KIND_ERROR;
                    idx_next   = '0;
                    u_next     = '0;
                    v_next     = '0;
                    state_next = S_EMIT;
                end

                if (do_break)
                begin
                    if (!first_reg)
                    begin
                        pen_y_next = pen_y_reg + step_y;
                        pen_x_next = '0;
                    end
                    first_next = 1'b0;
                end

                if (go_glyph)
                begin
                    kind_next = KIND_GLYPH;
                    idx_next  = glyph_n;
                    if (glyph_width_reg == '0)
                    begin
                        u_next     = '0;
                        v_next     = '0;
                        state_next = S_EMIT;
                    end
                    else if (cols_valid_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(glyph_n);
                        state_next       = S_DIVN;
                    end
                    else
                    begin
                        // column count = ceil(atlas_width / glyph_width)
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(atlas_width_reg) + DIV_W'(glyph_width_reg)
                                         - DIV_W'(1);
                        div_req.divisor  = DIV_W'(glyph_width_reg);
                        state_next       = S_COLS;
                    end
                end
            end
            S_COLS:
            begin
                if (div_rsp.done)
                begin
                    cols_next        = cols_calc;
                    cols_valid_next  = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(idx_reg);
                    div_req.divisor  = cols_calc;
                    state_next       = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_rsp.done)
                begin
                    quo_next   = div_rsp.quotient[6:0];
                    rem_next   = div_rsp.remainder[6:0];
                    state_next = S_MULU;
                end
            end
            S_MULU:
            begin
                u_next     = 16'(mul_p);
                state_next = S_MULV;
            end
            S_MULV:
            begin
                v_next     = 16'(mul_p);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_data_next  = {1'b0, v_reg, u_reg, screen_y, screen_x, idx_reg};
                    out_last_next  = !(second_reg && makes_result);
                    if (kind_reg == KIND_GLYPH)
                    begin
                        pen_x_next = pen_x_reg + step_x;
                    end
                    first_next = 1'b0;
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        state_next  = S_DECODE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // drop the cached column count when its inputs change
        if (cfg_we && (cfg_index == REG_GLYPH_WIDTH || cfg_index == REG_ATLAS_WIDTH))
        begin
            cols_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            origin_x_reg      <= 8'd0;
            origin_y_reg      <= 8'd0;
            glyph_width_reg   <= 8'd8;
            glyph_height_reg  <= 8'd8;
            glyph_padding_reg <= 8'd0;
            atlas_width_reg   <= 10'd256;
            pen_x_reg         <= '0;
            pen_y_reg         <= '0;
            first_reg         <= 1'b1;
            pending_reg       <= 1'b0;
            second_reg        <= 1'b0;
            cols_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            first_reg      <= first_next;
            pending_reg    <= pending_next;
            second_reg     <= second_next;
            cols_valid_reg <= cols_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ORIGIN_X:      origin_x_reg      <= cfg_wdata[7:0];
                    REG_ORIGIN_Y:      origin_y_reg      <= cfg_wdata[7:0];
                    REG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_wdata[7:0];
                    REG_GLYPH_HEIGHT:  glyph_height_reg  <= cfg_wdata[7:0];
                    REG_GLYPH_PADDING: glyph_padding_reg <= cfg_wdata[7:0];
                    REG_ATLAS_WIDTH:   atlas_width_reg   <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            char_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        cols_reg     <= cols_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/gle_div.sv
// Restoring divider, one quotient bit per cycle.
module gle_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gle_pkg::div_req_t req,
    output gle_pkg::div_rsp_t rsp
);
    import gle_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: tb/sv/glyph_layout_engine_tb.sv
// Self-checking testbench for the glyph layout engine: text byte requests in, glyph records out.
module glyph_layout_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gle_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        result_kind_t kind;
        logic [6:0]   glyph;
        logic [15:0]  scr_x;
        logic [15:0]  scr_y;
        logic [15:0]  atl_u;
        logic [15:0]  atl_v;
        logic         last;
    } glyph_rec_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_wdata = '0;

    // Layout state and registers as the engine should hold them
    logic [7:0]  org_x    = 8'd0;
    logic [7:0]  org_y    = 8'd0;
    logic [7:0]  cell_w   = 8'd8;
    logic [7:0]  cell_h   = 8'd8;
    logic [7:0]  cell_pad = 8'd0;
    logic [9:0]  atlas_w  = 10'd256;
    logic [15:0] pen_x    = '0;
    logic [15:0] pen_y    = '0;
    bit          line_start = 1'b1;
    bit          bs_held    = 1'b0;

    glyph_rec_t glyph_q[$];
    int         mismatches    = 0;
    int         sent_items    = 0;
    int         send_idle_pct = 30;
    int         recv_idle_pct = 59;
    int         cycle_count   = 0;
    int         hold_left     = 0;
    logic       hold_go       = 1'b0;

    glyph_layout_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        glyph_rec_t got;
        glyph_rec_t want;
        if (m_tvalid && m_tready)
        begin
            got.kind  = result_kind_t'(m_tuser);
            got.glyph = m_tdata[6:0];
            got.scr_x = m_tdata[22:7];
            got.scr_y = m_tdata[38:23];
            got.atl_u = m_tdata[54:39];
            got.atl_v = m_tdata[70:55];
            got.last  = m_tlast;
            if (glyph_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record: kind=%0d glyph=%0d x=%0d y=%0d u=%0d v=%0d last=%0d",
                             got.kind, got.glyph, got.scr_x, got.scr_y, got.atl_u, got.atl_v,
                             got.last);
            end
            else
            begin
                want = glyph_q.pop_front();
                if (got !== want || m_tdata[71] !== 1'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  want kind=%0d glyph=%0d x=%0d y=%0d u=%0d v=%0d last=%0d pad=0",
                                 want.kind, want.glyph, want.scr_x, want.scr_y, want.atl_u,
                                 want.atl_v, want.last);
                        $display("  got  kind=%0d glyph=%0d x=%0d y=%0d u=%0d v=%0d last=%0d pad=%0d",
                                 got.kind, got.glyph, got.scr_x, got.scr_y, got.atl_u,
                                 got.atl_v, got.last, m_tdata[71]);
                    end
                end
            end
        end
    end

    function automatic glyph_rec_t record_at(input result_kind_t kind, input logic [6:0] n);
        glyph_rec_t r;
        int cols;
        r.kind  = kind;
        r.glyph = n;
        r.scr_x = 16'(org_x + pen_x);
        r.scr_y = 16'(org_y + pen_y);
        r.atl_u = '0;
        r.atl_v = '0;
        r.last  = 1'b0;
        if (kind == KIND_GLYPH && cell_w != 0)
        begin
            cols = (int'(atlas_w) + int'(cell_w) - 1) / int'(cell_w);
            if (cols == 0)
                cols = 1;
            r.atl_u = 16'((int'(n) % cols) * int'(cell_w));
            r.atl_v = 16'((int'(n) / cols) * int'(cell_h));
        end
        return r;
    endfunction

    task automatic place_glyph(input logic [6:0] n);
        glyph_q.push_back(record_at(KIND_GLYPH, n));
        pen_x      = pen_x + 16'(cell_w) + 16'(cell_pad);
        line_start = 1'b0;
    endtask

    task automatic break_line();
        if (!line_start)
        begin
            pen_y = pen_y + 16'(cell_h) + 16'(cell_pad);
            pen_x = '0;
        end
        line_start = 1'b0;
    endtask

    // Queue the records one text byte should produce and advance the pen
    task automatic layout_char(input logic [7:0] c, input bit sot, input bit eot);
        int         depth;
        glyph_rec_t tail;
        depth = glyph_q.size();
        if (sot)
        begin
            pen_x      = '0;
            pen_y      = '0;
            line_start = 1'b1;
            bs_held    = 1'b0;
        end
        if (bs_held)
        begin
            bs_held = 1'b0;
            if (c == CH_LOWER_N)
            begin
                break_line();
                return;
            end
            place_glyph(GLYPH_BACKSLASH);
        end
        if (c == CH_NEWLINE)
            break_line();
        else if (c == CH_BACKSLASH)
        begin
            if (eot)
                place_glyph(GLYPH_BACKSLASH);
            else
                bs_held = 1'b1;
        end
        else if (c >= 8'd33 && c <= 8'd123)
            place_glyph(7'(c - 8'd33));
        else if (c >= 8'd124 && c <= 8'd126)
            place_glyph(7'(c - 8'd32));
        else if (c == CH_SPACE)
            place_glyph(GLYPH_SPACE);
        else
        begin
            glyph_q.push_back(record_at(KIND_ERROR, '0));
            line_start = 1'b0;
        end
        if (glyph_q.size() > depth)
        begin
            tail      = glyph_q.pop_back();
            tail.last = 1'b1;
            glyph_q.push_back(tail);
        end
    endtask

    // Leave s_tvalid high on return so back-to-back requests need no toggle
    task automatic send_char(input logic [7:0] c, input bit sot, input bit eot);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        layout_char(c, sot, eot);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= sot;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (glyph_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 10'(val);
        @(posedge clk);
    endtask

    task automatic apply_config(input int ox, input int oy, input int w, input int h,
                                input int pad, input int aw);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_GLYPH_WIDTH, w);
        write_reg(REG_GLYPH_HEIGHT, h);
        write_reg(REG_GLYPH_PADDING, pad);
        write_reg(REG_ATLAS_WIDTH, aw);
        cfg_we   <= 1'b0;
        org_x    = 8'(ox);
        org_y    = 8'(oy);
        cell_w   = 8'(w);
        cell_h   = 8'(h);
        cell_pad = 8'(pad);
        atlas_w  = 10'(aw);
    endtask

    function automatic int pick_value(input int lo, input int hi);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 62)
            return 8'($urandom_range(126, 33));
        if (r < 70)
            return CH_SPACE;
        if (r < 77)
            return CH_NEWLINE;
        if (r < 85)
            return CH_BACKSLASH;
        if (r < 89)
            return CH_LOWER_N;
        return 8'($urandom_range(255));
    endfunction

    // One text from start to end mark; a backslash is often followed by 'n'
    task automatic send_message(input int len);
        logic [7:0] c;
        logic [7:0] prev;
        prev = '0;
        for (int i = 0; i < len; i++)
        begin
            if (prev == CH_BACKSLASH && $urandom_range(1) == 1)
                c = CH_LOWER_N;
            else
                c = pick_char();
            send_char(c, i == 0, i == len - 1);
            prev = c;
        end
    endtask

    task automatic run_text(input int n_items);
        int first;
        int cfg_mark;
        first    = sent_items;
        cfg_mark = sent_items;
        while (sent_items - first < n_items)
        begin
            if ($urandom_range(99) < 85)
                send_message($urandom_range(30, 1));
            else
                repeat ($urandom_range(5, 1))
                    send_char(8'($urandom_range(255)), $urandom_range(9) == 0,
                              $urandom_range(9) == 0);
            if (sent_items - cfg_mark >= 120)
            begin
                apply_config(pick_value(0, 255), pick_value(0, 255), pick_value(1, 255),
                             pick_value(1, 255), pick_value(0, 255), pick_value(1, 1023));
                cfg_mark = sent_items;
            end
        end
    endtask

    task automatic test_directed();
        send_char(CH_NEWLINE, 1, 0);      // break at the first position: pen stays
        send_char(8'd33, 0, 0);
        send_char(8'd123, 0, 0);
        send_char(8'd124, 0, 0);
        send_char(8'd126, 0, 0);
        send_char(CH_SPACE, 0, 0);
        send_char(8'd0, 0, 0);
        send_char(8'd31, 0, 0);
        send_char(8'd127, 0, 0);
        send_char(8'd255, 0, 0);
        send_char(8'd128, 0, 0);
        send_char(CH_NEWLINE, 0, 0);
        send_char("A", 0, 0);             // byte after a real newline is kept
        send_char(CH_BACKSLASH, 0, 0);
        send_char(CH_LOWER_N, 0, 0);
        send_char(CH_BACKSLASH, 0, 0);
        send_char("x", 0, 0);             // held backslash plus this glyph
        send_char(CH_BACKSLASH, 0, 1);    // flushed by the end mark
        send_char(CH_BACKSLASH, 1, 0);
        send_char(CH_LOWER_N, 0, 0);      // escaped break at the first position
        send_char(CH_BACKSLASH, 0, 0);
        send_char(CH_NEWLINE, 0, 0);
        send_char(CH_BACKSLASH, 0, 0);
        send_char("B", 1, 0);             // new text drops the held backslash
        send_char(CH_BACKSLASH, 0, 0);
        send_char(CH_BACKSLASH, 0, 1);
    endtask

    task automatic test_config_extremes();
        apply_config(255, 255, 255, 255, 255, 1023);
        run_text(50);
        apply_config(0, 0, 1, 1, 0, 1);
        run_text(50);
        apply_config(0, 255, 255, 1, 0, 1);
        run_text(50);
        apply_config(255, 0, 1, 255, 255, 1023);
        run_text(50);
        apply_config(0, 0, 8, 8, 0, 256);
        run_text(50);
    endtask

    // Push the pen past 16 bits in both directions
    task automatic test_pen_wrap();
        apply_config(255, 255, 255, 255, 255, 1023);
        for (int i = 0; i < 130; i++)
            send_char(8'($urandom_range(126, 33)), i == 0, 0);
        repeat (130) send_char(CH_NEWLINE, 0, 0);
        send_char("Z", 0, 1);
    endtask

    task automatic test_random_text(input int snd_pct, input int rcv_pct, input int n_items);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        run_text(n_items);
    endtask

    // Stall the result side long enough that the engine refuses new bytes
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        send_message(30);
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_config_extremes();
        test_pen_wrap();
        test_random_text(30, 59, 380);
        test_random_text(59, 30, 380);
        test_backpressure();
        test_random_text(0, 0, 380);
        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: glyph_layout_engine.f
hdl/gle_pkg.sv
hdl/gle_div.sv
hdl/glyph_layout_engine.sv
tb/sv/glyph_layout_engine_tb.sv
